// ----- rtl/rse_pkg.sv -----
// ----------------------------------------------------------------------------
// rse_pkg: shared types and constants
// Opcodes, error codes and payload structs of the register/stack execute unit.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int DEF_NUM_REGS    = 10;
    localparam int DEF_STACK_DEPTH = 128;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [3:0] {
        OP_MOVI  = 4'd0,
        OP_MOV   = 4'd1,
        OP_ADD   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_CMP   = 4'd5,
        OP_PUSHI = 4'd6,
        OP_PUSH  = 4'd7,
        OP_POP   = 4'd8,
        OP_DEC   = 4'd9,
        OP_JNZ   = 4'd10,
        OP_HLT   = 4'd11,
        OP_NOP12 = 4'd12,
        OP_NOP13 = 4'd13,
        OP_NOP14 = 4'd14,
        OP_NOP15 = 4'd15
    } t_opcode;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_OVERFLOW  = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_DIV_ZERO  = 3'd3,
        ERR_BAD_REG   = 3'd4
    } t_err;

    typedef struct packed {
        logic [3:0] opcode;
        logic [3:0] src_reg;
        logic [3:0] dst_reg;
        logic [6:0] immediate;
    } t_in_item;

    typedef struct packed {
        logic        wrote;
        logic [3:0]  written_reg;
        logic [31:0] written_value;
        logic        not_equal;
        logic        branch_taken;
        logic [6:0]  branch_target;
        logic [7:0]  stack_depth;
        logic [2:0]  error_code;
        logic        halted;
    } t_out_item;

    // classified instruction handed from front to back
    typedef struct packed {
        t_opcode    op;
        logic [3:0] src;
        logic [3:0] dst;
        logic [6:0] imm;
        logic       bad_reg;
    } t_cmd;

endpackage

// ----- rtl/rse_front.sv -----
// ----------------------------------------------------------------------------
// rse_front: accept and classify
// Checks register indices and queues classified commands for the back end.
// ----------------------------------------------------------------------------
module rse_front #(
    parameter int NUM_REGS = rse_pkg::DEF_NUM_REGS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rse_pkg::t_in_item i_data,
    output logic              o_cmd_valid,
    input  logic              i_cmd_take,
    output rse_pkg::t_cmd     o_cmd
);
    import rse_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd          r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          need_s, need_d, push, pop;
    t_cmd          cmd;

    always_comb begin
        need_s = 1'b0;
        need_d = 1'b0;
        unique case (t_opcode'(i_data.opcode))
            OP_MOVI, OP_POP, OP_DEC: need_d = 1'b1;
            OP_MOV, OP_ADD, OP_MUL, OP_DIV, OP_CMP: begin
                need_s = 1'b1;
                need_d = 1'b1;
            end
            OP_PUSH: need_s = 1'b1;
            default: ;
        endcase
        cmd.op      = t_opcode'(i_data.opcode);
        cmd.src     = i_data.src_reg;
        cmd.dst     = i_data.dst_reg;
        cmd.imm     = i_data.immediate;
        cmd.bad_reg = (need_s && ({1'b0, i_data.src_reg} >= 5'(NUM_REGS)))
                   || (need_d && ({1'b0, i_data.dst_reg} >= 5'(NUM_REGS)));
    end

    assign o_stall     = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count overrun");
    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> !push) else $error("push into full queue");
    a_empty_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cmd_valid |-> !pop) else $error("pop from empty queue");

endmodule

// ----- rtl/rse_divider.sv -----
// ----------------------------------------------------------------------------
// rse_divider: iterative signed divider
// Restoring division, one quotient bit per cycle, truncation toward zero.
// ----------------------------------------------------------------------------
module rse_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    import rse_pkg::*;

    logic [31:0] r_q, r_d;
    logic [32:0] r_rem;
    logic [4:0]  r_idx;
    logic        r_busy, r_neg, r_done;
    logic [32:0] trial;
    logic [31:0] ua, ub;

    assign ua    = i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
    assign ub    = i_divisor[31]  ? (32'd0 - i_divisor)  : i_divisor;
    assign trial = {r_rem[31:0], r_q[31]} - {1'b0, r_d};

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (32'd0 - r_q) : r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= ua;
            r_d   <= ub;
            r_rem <= '0;
            r_neg <= i_dividend[31] ^ i_divisor[31];
            r_idx <= '0;
        end else if (r_busy) begin
            if (!trial[32]) begin
                r_rem <= trial;
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_q[31]};
                r_q   <= {r_q[30:0], 1'b0};
            end
            r_idx <= r_idx + 1'b1;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_idx == 5'd31);
            if (i_start) r_busy <= 1'b1;
            else if (r_busy && r_idx == 5'd31) r_busy <= 1'b0;
        end
    end

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without run");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("start while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");

endmodule

// ----- rtl/rse_back.sv -----
// ----------------------------------------------------------------------------
// rse_back: execute
// Register file, stack memory, flags, divider control and output register.
// ----------------------------------------------------------------------------
module rse_back #(
    parameter int NUM_REGS    = rse_pkg::DEF_NUM_REGS,
    parameter int STACK_DEPTH = rse_pkg::DEF_STACK_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_take,
    input  rse_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  logic               i_stall,
    output rse_pkg::t_out_item o_data
);
    import rse_pkg::*;

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int RW = $clog2(NUM_REGS);

    typedef enum logic [2:0] {S_IDLE, S_POPRD, S_DIV, S_OUT} t_state;

    t_state       r_state;
    logic [31:0]  r_rf [NUM_REGS];
    logic [31:0]  r_stk [STACK_DEPTH];
    logic [31:0]  r_stk_q;
    logic [8:0]   r_cnt;
    logic [8:0]   n_cnt;
    logic         r_ne, r_halt;
    t_cmd         r_cmd;
    t_out_item    r_out;
    logic         r_ov;
    logic [31:0]  vs, vd;
    logic         div_start, div_done;
    logic [31:0]  quot;
    t_out_item    res;
    logic         wen;
    logic [RW-1:0] wa;
    logic [31:0]  wv;

    assign vs = r_rf[RW'(i_cmd.src)];
    assign vd = r_rf[RW'(i_cmd.dst)];

    rse_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (vd),
        .i_divisor  (vs),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    assign o_valid = r_ov;
    assign o_data  = r_out;

    // take a command only from idle with the output slot free
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid && (!r_ov || !i_stall);
    assign div_start  = o_cmd_take && !r_halt && !i_cmd.bad_reg
                        && i_cmd.op == OP_DIV && vs != 32'd0;

    always_comb begin
        res = '0;
        res.not_equal   = r_ne;
        res.stack_depth = r_cnt[7:0];
        res.halted      = r_halt;
        n_cnt = r_cnt;
        wen = 1'b0;
        wa  = RW'(i_cmd.dst);
        wv  = '0;
        if (!r_halt) begin
            if (i_cmd.bad_reg) begin
                res.error_code = ERR_BAD_REG;
            end else begin
                unique case (i_cmd.op)
                    OP_MOVI: begin wen = 1'b1; wv = 32'(i_cmd.imm); end
                    OP_MOV:  begin wen = 1'b1; wv = vs; end
                    OP_ADD:  begin wen = 1'b1; wv = vs + vd; end
                    OP_MUL:  begin wen = 1'b1; wv = vs * vd; end
                    OP_DIV:  if (vs == 32'd0) res.error_code = ERR_DIV_ZERO;
                    OP_CMP:  res.not_equal = (vd != vs);
                    OP_PUSHI, OP_PUSH: begin
                        if (r_cnt >= 9'(STACK_DEPTH)) begin
                            res.error_code = ERR_OVERFLOW;
                        end else begin
                            n_cnt           = r_cnt + 9'd1;
                            res.stack_depth = n_cnt[7:0];
                        end
                    end
                    OP_POP: begin
                        if (r_cnt == '0) res.error_code = ERR_UNDERFLOW;
                    end
                    OP_DEC:  begin wen = 1'b1; wv = vd - 32'd1; end
                    OP_JNZ: begin
                        res.branch_taken  = r_ne;
                        res.branch_target = r_ne ? i_cmd.imm : 7'd0;
                    end
                    OP_HLT:  res.halted = 1'b1;
                    default: ;
                endcase
            end
        end
        if (wen) begin
            res.wrote         = 1'b1;
            res.written_reg   = i_cmd.dst;
            res.written_value = wv;
        end
    end

    always_ff @(posedge i_clk) begin
        // register file writes
        if (o_cmd_take && wen) r_rf[wa] <= wv;
        if (r_state == S_DIV && div_done) r_rf[RW'(r_cmd.dst)] <= quot;
        if (r_state == S_POPRD) r_rf[RW'(r_cmd.dst)] <= r_stk_q;
        // stack memory
        if (o_cmd_take && !r_halt && !i_cmd.bad_reg
            && (i_cmd.op == OP_PUSH || i_cmd.op == OP_PUSHI)
            && r_cnt < 9'(STACK_DEPTH)) begin
            r_stk[SW'(r_cnt)] <= (i_cmd.op == OP_PUSHI) ? 32'(i_cmd.imm) : vs;
        end
        r_stk_q <= r_stk[SW'(r_cnt - 9'd1)];
        if (o_cmd_take) r_cmd <= i_cmd;

        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) r_rf[k] <= '0;
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ne    <= 1'b0;
            r_halt  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_ne   <= res.not_equal;
                        r_halt <= res.halted;
                        r_cnt  <= n_cnt;
                        r_out  <= res;
                        if (div_start) begin
                            r_state <= S_DIV;
                        end else if (!r_halt && !i_cmd.bad_reg
                                     && i_cmd.op == OP_POP && r_cnt != '0) begin
                            r_state <= S_POPRD;
                        end else begin
                            r_ov <= 1'b1;
                        end
                    end
                end
                S_POPRD: begin
                    r_cnt                <= r_cnt - 9'd1;
                    r_out.wrote          <= 1'b1;
                    r_out.written_reg    <= r_cmd.dst;
                    r_out.written_value  <= r_stk_q;
                    r_out.stack_depth    <= 8'(r_cnt - 9'd1);
                    r_ov                 <= 1'b1;
                    r_state              <= S_IDLE;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_out.wrote         <= 1'b1;
                        r_out.written_reg   <= r_cmd.dst;
                        r_out.written_value <= quot;
                        r_ov                <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 9'(STACK_DEPTH)) else $error("stack count overrun");
    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt cleared");
    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd_take) else $error("take while busy");

endmodule

// ----- rtl/register_stack_execute_unit.sv -----
// ----------------------------------------------------------------------------
// register_stack_execute_unit: decoded-instruction executor
// Front classifier, two-entry command queue and execute back end.
// ----------------------------------------------------------------------------
// One instruction is taken per transfer and gives exactly one result
// transfer. Most opcodes pass through the queue and then the back end, which
// registers the result. Pop adds a registered stack-memory read. A divide by a
// non-zero register runs the iterative divider, one quotient bit per cycle:
// the command leaves the queue and starts the divider, which forms 32 quotient
// bits and then raises its done flag. Output stalls delay the result transfer.
// The two-entry front queue keeps taking instructions while the back end
// works, until it is full.
module register_stack_execute_unit #(
    parameter int NUM_REGS    = rse_pkg::DEF_NUM_REGS,
    parameter int STACK_DEPTH = rse_pkg::DEF_STACK_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rse_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output rse_pkg::t_out_item  o_data
);
    import rse_pkg::*;

    t_cmd cmd;
    logic cmd_valid, cmd_take;

    // classify and queue
    rse_front #(.NUM_REGS(NUM_REGS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take),
        .o_cmd       (cmd)
    );

    // execute and hold the result until its transfer
    rse_back #(.NUM_REGS(NUM_REGS), .STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_take  (cmd_take),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule
